@@ rtl/lfpd_pkg.sv @@
// ----------------------------------------------------------------------------
// lfpd_pkg: shared types and constants of the line follower PD drive
// Field widths, sensor geometry, register codes and the motor drive helper.
// ----------------------------------------------------------------------------
package lfpd_pkg;

   // sensor geometry
   localparam int SENSOR_COUNT = 7;
   localparam int SENSOR_W     = 10;
   localparam int CENTER       = (SENSOR_COUNT - 1) / 2;
   localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);
   localparam int POS_W        = 5;    // holds -CENTER .. SENSOR_COUNT-CENTER

   // weighted sum stays within +-60 for the seven sensor geometry
   localparam int SUM_W        = 10;
   localparam int MAG_W        = SUM_W - 1;

   // error path
   localparam int ERR_W        = 7;
   localparam int DIFF_W       = ERR_W + 1;
   localparam int GAIN_W       = 4;
   localparam int PROD_W       = 12;
   localparam int PD_W         = PROD_W + 1;
   localparam int SPEED_W      = 9;
   localparam int DRIVE_W      = PD_W + 1;
   localparam int DUTY_W       = 8;
   localparam int THR_W        = 10;

   // sequencer step counter covers the scan and the divider
   localparam int MAX_STEPS    = (SENSOR_COUNT > MAG_W) ? SENSOR_COUNT : MAG_W;
   localparam int STEP_W       = $clog2(MAX_STEPS);

   // stream and register port widths
   localparam int REQ_W        = ((SENSOR_COUNT * SENSOR_W + 7) / 8) * 8;
   localparam int RSP_W        = 32;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 10;

   // limits
   localparam logic signed [ERR_W-1:0]   ERR_MAX     = ERR_W'(63);
   localparam logic signed [ERR_W-1:0]   ERR_MIN     = ERR_W'(-64);
   localparam logic signed [ERR_W-1:0]   LOST_HIGH   = ERR_W'(20);
   localparam logic signed [ERR_W-1:0]   LOST_LOW    = ERR_W'(-20);
   localparam logic signed [ERR_W-1:0]   LOST_RIGHT  = ERR_W'(40);
   localparam logic signed [ERR_W-1:0]   LOST_LEFT   = ERR_W'(-40);
   localparam logic signed [DRIVE_W-1:0] DRIVE_HI    = DRIVE_W'(250);
   localparam logic signed [DRIVE_W-1:0] DRIVE_LO    = DRIVE_W'(-250);
   localparam logic [DUTY_W-1:0]         DUTY_MAX    = DUTY_W'(250);

   // overshoot side codes
   localparam logic [1:0] SIDE_NONE  = 2'd0;
   localparam logic [1:0] SIDE_LEFT  = 2'd1;
   localparam logic [1:0] SIDE_RIGHT = 2'd2;

   // register reset values
   localparam logic [THR_W-1:0]          THR_RESET   = '0;
   localparam logic [GAIN_W-1:0]         PGAIN_RESET = GAIN_W'(2);
   localparam logic [GAIN_W-1:0]         DGAIN_RESET = GAIN_W'(2);
   localparam logic signed [SPEED_W-1:0] BASE_RESET  = SPEED_W'(100);

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_THRESHOLD  = 2'd0,
      REG_PROP_GAIN  = 2'd1,
      REG_DERIV_GAIN = 2'd2,
      REG_BASE_SPEED = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic div_init;
      logic div_step;
      logic err;
      logic mul;
      logic pd;
      logic drive;
   } lfpd_cmd_type;

   typedef struct packed {
      logic out_busy;
   } lfpd_sts_type;

   typedef struct packed {
      logic              fwd;
      logic [DUTY_W-1:0] duty;
   } lfpd_drive_type;

   // saturate a drive value to +-250 and split it into duty and direction
   function automatic lfpd_drive_type drive_out(input logic signed [DRIVE_W-1:0] v);
      lfpd_drive_type d;
      if (v > DRIVE_HI) begin
         d.duty = DUTY_MAX;
         d.fwd  = 1'b1;
      end else if (v < DRIVE_LO) begin
         d.duty = DUTY_MAX;
         d.fwd  = 1'b0;
      end else if (v[DRIVE_W-1]) begin
         d.duty = DUTY_W'(-v);
         d.fwd  = 1'b0;
      end else begin
         d.duty = DUTY_W'(v);
         d.fwd  = (v != '0);
      end
      return d;
   endfunction

endpackage

@@ rtl/lfpd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfpd_ctrl: sequencer of the line follower PD drive
// Walks one scan through sensor accumulation, division, error update,
// gain multiply, PD sum and output drive.
// ----------------------------------------------------------------------------
module lfpd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  lfpd_pkg::lfpd_sts_type sts,
   output lfpd_pkg::lfpd_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIVINIT,
      ST_DIV,
      ST_ERR,
      ST_MUL,
      ST_PD,
      ST_DRIVE
   } state_type;

   state_type                   state_ff, state_in;
   logic [lfpd_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        ready_ff, ready_in;
   logic                        accept;

   // hold off transfers while reset is high
   assign req_tready = ready_ff && !reset;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.scan     = (state_ff == ST_SCAN);
      cmd.div_init = (state_ff == ST_DIVINIT);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.err      = (state_ff == ST_ERR);
      cmd.mul      = (state_ff == ST_MUL);
      cmd.pd       = (state_ff == ST_PD);
      cmd.drive    = (state_ff == ST_DRIVE) && !sts.out_busy;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ready_in = ready_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               step_in  = lfpd_pkg::STEP_W'(lfpd_pkg::SENSOR_COUNT - 1);
               ready_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (step_ff == '0) state_in = ST_DIVINIT;
            else               step_in  = step_ff - 1'b1;
         end
         ST_DIVINIT: begin
            state_in = ST_DIV;
            step_in  = lfpd_pkg::STEP_W'(lfpd_pkg::MAG_W - 1);
         end
         ST_DIV: begin
            if (step_ff == '0) state_in = ST_ERR;
            else               step_in  = step_ff - 1'b1;
         end
         ST_ERR:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_PD;
         ST_PD:   state_in = ST_DRIVE;
         ST_DRIVE: begin
            // hold until the output register is free
            if (!sts.out_busy) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ready_ff <= ready_in;
      end
   end

endmodule

@@ rtl/lfpd_dp.sv @@
// ----------------------------------------------------------------------------
// lfpd_dp: datapath of the line follower PD drive
// Configuration registers, serial sensor accumulation, restoring divider,
// error and overshoot state, gain multipliers and the output register.
// ----------------------------------------------------------------------------
module lfpd_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  lfpd_pkg::lfpd_cmd_type            cmd,
   output lfpd_pkg::lfpd_sts_type            sts,
   input  logic [lfpd_pkg::REQ_W-1:0]        req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lfpd_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                              csr_valid,
   input  logic [lfpd_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SENS_BITS = lfpd_pkg::SENSOR_COUNT * lfpd_pkg::SENSOR_W;

   // configuration
   logic [lfpd_pkg::THR_W-1:0]          thr_ff;
   logic [lfpd_pkg::GAIN_W-1:0]         pgain_ff;
   logic [lfpd_pkg::GAIN_W-1:0]         dgain_ff;
   logic signed [lfpd_pkg::SPEED_W-1:0] base_ff;

   // scan accumulation
   logic [SENS_BITS-1:0]                sens_ff, sens_in;
   logic signed [lfpd_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic signed [lfpd_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [lfpd_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic                                half_ff, half_in;

   // divider
   logic [lfpd_pkg::MAG_W-1:0]          quo_ff, quo_in;
   logic [lfpd_pkg::CNT_W-1:0]          rem_ff, rem_in;
   logic                                neg_ff, neg_in;

   // loop state
   logic signed [lfpd_pkg::ERR_W-1:0]   last_ff, last_in;
   logic signed [lfpd_pkg::ERR_W-1:0]   prev_ff, prev_in;
   logic [1:0]                          flag_ff, flag_in;

   // error and PD terms
   logic signed [lfpd_pkg::ERR_W-1:0]   err_ff, err_in;
   logic signed [lfpd_pkg::DIFF_W-1:0]  diff_ff, diff_in;
   logic                                lost_ff, lost_in;
   logic signed [lfpd_pkg::PROD_W-1:0]  pterm_ff, pterm_in;
   logic signed [lfpd_pkg::PROD_W-1:0]  dterm_ff, dterm_in;
   logic signed [lfpd_pkg::PD_W-1:0]    pd_ff, pd_in;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [lfpd_pkg::RSP_W-1:0]          rsp_data_ff, rsp_data_in;

   // scratch
   logic signed [lfpd_pkg::SUM_W-1:0]   pos_ext, term5, term;
   logic                                lit;
   logic [lfpd_pkg::CNT_W:0]            trial;
   logic signed [lfpd_pkg::ERR_W-1:0]   quot_err, err_v;
   logic [1:0]                          flag_v;
   logic signed [lfpd_pkg::DRIVE_W-1:0] left_v, right_v;
   lfpd_pkg::lfpd_drive_type            left_d, right_d;

   assign sts.out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= lfpd_pkg::THR_RESET;
         pgain_ff <= lfpd_pkg::PGAIN_RESET;
         dgain_ff <= lfpd_pkg::DGAIN_RESET;
         base_ff  <= lfpd_pkg::BASE_RESET;
      end else if (csr_valid) begin
         unique case (lfpd_pkg::csr_reg_type'(csr_index))
            lfpd_pkg::REG_THRESHOLD:  thr_ff   <= csr_wdata[lfpd_pkg::THR_W-1:0];
            lfpd_pkg::REG_PROP_GAIN:  pgain_ff <= csr_wdata[lfpd_pkg::GAIN_W-1:0];
            lfpd_pkg::REG_DERIV_GAIN: dgain_ff <= csr_wdata[lfpd_pkg::GAIN_W-1:0];
            lfpd_pkg::REG_BASE_SPEED: base_ff  <= csr_wdata[lfpd_pkg::SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // current sensor weight: position times 5 in overshoot, times 10 otherwise
   always_comb begin
      pos_ext = lfpd_pkg::SUM_W'(pos_ff);
      term5   = (pos_ext <<< 2) + pos_ext;
      term    = half_ff ? term5 : (term5 <<< 1);
      lit     = sens_ff[lfpd_pkg::SENSOR_W-1:0] > thr_ff;
      trial   = {rem_ff, quo_ff[lfpd_pkg::MAG_W-1]};
   end

   // signed, clamped quotient
   always_comb begin
      if (neg_ff) begin
         if (quo_ff > lfpd_pkg::MAG_W'(64)) quot_err = lfpd_pkg::ERR_MIN;
         else                               quot_err = lfpd_pkg::ERR_W'(-quo_ff);
      end else begin
         if (quo_ff > lfpd_pkg::MAG_W'(63)) quot_err = lfpd_pkg::ERR_MAX;
         else                               quot_err = lfpd_pkg::ERR_W'(quo_ff);
      end
   end

   // error selection and overshoot tracking
   always_comb begin
      flag_v = flag_ff;
      if (cnt_ff != '0) begin
         err_v = quot_err;
      end else if (last_ff < lfpd_pkg::LOST_LOW) begin
         err_v  = lfpd_pkg::LOST_LEFT;
         flag_v = lfpd_pkg::SIDE_LEFT;
      end else if (last_ff > lfpd_pkg::LOST_HIGH) begin
         err_v  = lfpd_pkg::LOST_RIGHT;
         flag_v = lfpd_pkg::SIDE_RIGHT;
      end else begin
         err_v = '0;
      end
      // clear once the error is back on the other side of center
      if (flag_v == lfpd_pkg::SIDE_LEFT && !err_v[lfpd_pkg::ERR_W-1])
         flag_v = lfpd_pkg::SIDE_NONE;
      else if (flag_v == lfpd_pkg::SIDE_RIGHT && (err_v[lfpd_pkg::ERR_W-1] || err_v == '0))
         flag_v = lfpd_pkg::SIDE_NONE;
   end

   always_comb begin
      left_v  = lfpd_pkg::DRIVE_W'(base_ff) + lfpd_pkg::DRIVE_W'(pd_ff);
      right_v = lfpd_pkg::DRIVE_W'(base_ff) - lfpd_pkg::DRIVE_W'(pd_ff);
      left_d  = lfpd_pkg::drive_out(left_v);
      right_d = lfpd_pkg::drive_out(right_v);
   end

   always_comb begin
      sens_in      = sens_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      half_in      = half_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      flag_in      = flag_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      lost_in      = lost_ff;
      pterm_in     = pterm_ff;
      dterm_in     = dterm_ff;
      pd_in        = pd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         sens_in = req_tdata[SENS_BITS-1:0];
         pos_in  = lfpd_pkg::POS_W'(-lfpd_pkg::CENTER);
         sum_in  = '0;
         cnt_in  = '0;
         half_in = (flag_ff != lfpd_pkg::SIDE_NONE);
      end

      if (cmd.scan) begin
         if (lit) begin
            sum_in = sum_ff + term;
            cnt_in = cnt_ff + 1'b1;
         end
         sens_in = sens_ff >> lfpd_pkg::SENSOR_W;
         pos_in  = pos_ff + 1'b1;
      end

      if (cmd.div_init) begin
         neg_in = sum_ff[lfpd_pkg::SUM_W-1];
         quo_in = sum_ff[lfpd_pkg::SUM_W-1] ? lfpd_pkg::MAG_W'(-sum_ff)
                                           : lfpd_pkg::MAG_W'(sum_ff);
         rem_in = '0;
      end

      // one quotient bit per step, shifted in behind the dividend
      if (cmd.div_step) begin
         if (trial >= {1'b0, cnt_ff}) begin
            rem_in = lfpd_pkg::CNT_W'(trial - {1'b0, cnt_ff});
            quo_in = {quo_ff[lfpd_pkg::MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[lfpd_pkg::CNT_W-1:0];
            quo_in = {quo_ff[lfpd_pkg::MAG_W-2:0], 1'b0};
         end
      end

      if (cmd.err) begin
         err_in  = err_v;
         lost_in = (cnt_ff == '0);
         flag_in = flag_v;
         diff_in = lfpd_pkg::DIFF_W'(err_v) - lfpd_pkg::DIFF_W'(prev_ff);
         prev_in = err_v;
         if (cnt_ff != '0) last_in = err_v;
      end

      if (cmd.mul) begin
         pterm_in = lfpd_pkg::PROD_W'($signed({1'b0, pgain_ff})) * lfpd_pkg::PROD_W'(err_ff);
         dterm_in = lfpd_pkg::PROD_W'($signed({1'b0, dgain_ff})) * lfpd_pkg::PROD_W'(diff_ff);
      end

      if (cmd.pd) begin
         pd_in = lfpd_pkg::PD_W'(pterm_ff) + lfpd_pkg::PD_W'(dterm_ff);
      end

      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.drive) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0, flag_ff, lost_ff, err_ff,
                         right_d.fwd, right_d.duty, left_d.fwd, left_d.duty};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         prev_ff      <= '0;
         flag_ff      <= lfpd_pkg::SIDE_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         prev_ff      <= prev_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sens_ff     <= sens_in;
      pos_ff      <= pos_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      half_ff     <= half_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      err_ff      <= err_in;
      diff_ff     <= diff_in;
      lost_ff     <= lost_in;
      pterm_ff    <= pterm_in;
      dterm_ff    <= dterm_in;
      pd_ff       <= pd_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/line_follower_pd_drive.sv @@
// ----------------------------------------------------------------------------
// line_follower_pd_drive: PD steering for a seven sensor line follower
// One scan of sensor readings in, one pair of motor commands out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one scan per transfer. rsp_* returns one result per scan:
//   duty and direction for both motors, the line error, a line lost flag and
//   the overshoot side. csr_* writes threshold, gains and base speed; write
//   it only while no scan is in flight. csr_ready is high outside reset.
// Timing:
//   The sequencer handles one scan at a time. The sensors are accumulated
//   one per cycle, the divider is set up and then yields one quotient bit
//   per cycle (MAG_W bits), then error, multiply, PD sum and drive follow
//   in turn. The result shows on rsp_tvalid in the same cycle as req_tready
//   rises, so a new scan is only taken once the last one is through.
// Reset:
//   Registers go to their defaults, the loop state clears, no result is held.
//   req_tready and csr_ready stay low while reset is high.
// Stall:
//   A result waits in the output register while rsp_tready is low; the next
//   scan is accepted and computed meanwhile and waits at its drive step.
// ----------------------------------------------------------------------------
module line_follower_pd_drive (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // sensor_0 [9:0], sensor_1 .. sensor_6 upward in 10-bit steps, zero pad
   input  logic [lfpd_pkg::REQ_W-1:0]      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // left_duty[7:0], left_forward[8], right_duty[16:9], right_forward[17],
   // line_error[24:18], line_lost[25], overshoot_side[27:26], zero pad
   output logic [lfpd_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lfpd_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   lfpd_pkg::lfpd_cmd_type cmd;
   lfpd_pkg::lfpd_sts_type sts;

   assign csr_ready = !reset;

   lfpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lfpd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

@@ rtl/lfpd_checker.sv @@
// ----------------------------------------------------------------------------
// lfpd_checker: port-level checks of the line follower PD drive
// Watches the stream ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module lfpd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lfpd_pkg::RSP_W-1:0]      rsp_tdata
);

   // no result survives reset
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one scan in flight: tready drops after a transfer
   a_one_scan: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second scan accepted while busy");

   // duties saturate and a forward bit never comes with zero duty
   a_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:0] <= 8'd250 && rsp_tdata[16:9] <= 8'd250
                     && (!rsp_tdata[8] || rsp_tdata[7:0] != 8'd0)
                     && (!rsp_tdata[17] || rsp_tdata[16:9] != 8'd0))
      else $error("drive value out of range");

   // a lost line gives only the hard turn or zero error
   a_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25] |->
         (rsp_tdata[24:18] == 7'd0 || rsp_tdata[24:18] == 7'h58
          || rsp_tdata[24:18] == 7'd40) && rsp_tdata[27:26] != 2'd3)
      else $error("bad error for lost line");

endmodule

bind line_follower_pd_drive lfpd_checker u_lfpd_checker (.*);
